// ===== hw/rtl/lsbg_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbg_pkg: shared types and helpers for the lidar scan breakpoint grouper
// Holds register indexes, command and status structs, the arctangent table
// and the truncating shift used by the rotation iterations.
// ----------------------------------------------------------------------------
`default_nettype none
package lsbg_pkg;

	localparam int RANGE_W  = 16;
	localparam int IDX_W    = 12;
	localparam int CNT_W    = 13;
	localparam int COORD_W  = 17;
	localparam int ANG_W    = 16;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 16;
	localparam int ROT_W    = 33;
	localparam int ZW       = 18;
	localparam int ITER_W   = 4;
	localparam int IN_DW    = 16;
	localparam int OUT_DW   = 112;
	localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
	localparam logic signed [ROT_W-1:0] CORDIC_K = 33'sd652032875;
	localparam logic [19:0] COORD_MAX = 20'd65535;

	typedef enum logic [CFG_AW-1:0] {
		REG_MIN_RANGE  = 3'd0,
		REG_MAX_RANGE  = 3'd1,
		REG_ANG_START  = 3'd2,
		REG_ANG_STEP   = 3'd3,
		REG_GAP        = 3'd4,
		REG_GAP_PER_R  = 3'd5,
		REG_VIS_SINE   = 3'd6,
		REG_MIN_POINTS = 3'd7
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              iter_en;
		logic [ITER_W-1:0] iter;
		logic              scale;
		logic              round;
		logic              mul1;
		logic              mul2;
		logic              decide;
		logic              start;
		logic              add_pt;
		logic              emit_brk;
		logic              emit_last;
		logic              close;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic kept;
		logic last;
		logic grp_open;
		logic near;
		logic out_free;
	} sts_t;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [ITER_W-1:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			4'd0:  a = 18'sd8192;
			4'd1:  a = 18'sd4836;
			4'd2:  a = 18'sd2555;
			4'd3:  a = 18'sd1297;
			4'd4:  a = 18'sd651;
			4'd5:  a = 18'sd326;
			4'd6:  a = 18'sd163;
			4'd7:  a = 18'sd81;
			4'd8:  a = 18'sd41;
			4'd9:  a = 18'sd20;
			4'd10: a = 18'sd10;
			4'd11: a = 18'sd5;
			4'd12: a = 18'sd3;
			4'd13: a = 18'sd1;
			4'd14: a = 18'sd1;
			default: a = 18'sd0;
		endcase
		return a;
	endfunction

	// arithmetic shift that truncates toward zero
	function automatic logic signed [ROT_W-1:0] shr_tz(input logic signed [ROT_W-1:0] v,
			input logic [ITER_W-1:0] s);
		logic [ROT_W-1:0] mag;
		logic [ROT_W-1:0] sh;
		mag = v[ROT_W-1] ? ROT_W'(-v) : ROT_W'(v);
		sh  = mag >> s;
		return v[ROT_W-1] ? -$signed(sh) : $signed(sh);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lidar_scan_breakpoint_grouper_core.sv =====
// Sequence: a kept beam, once accepted, passes the shared rotation unit, scaling,
// rounding, two multiplier steps and the decision, then updates the group; a
// closed group is written to the result register. A dropped beam skips all that.
// One beam is in flight at a time; a scan's last beam adds a state for its result,
// and a break or scan end waits while the result register is still full.
// Reset: asynchronous, active low; clears control and beam count, config to defaults.
// ----------------------------------------------------------------------------
// lidar_scan_breakpoint_grouper_core: adaptive breakpoint grouping of a scan
// Turns ranges into points and groups neighbours, one result per group.
// ----------------------------------------------------------------------------
`default_nettype none
module lidar_scan_breakpoint_grouper_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [lsbg_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire  [lsbg_pkg::CFG_DW-1:0]  cfg_wdata,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [lsbg_pkg::IN_DW-1:0]   s_tdata,  // range_mm
	input  wire                          s_tlast,  // last_beam
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// first_index, end_index, point_count, visible, large_enough,
	// first_x, first_y, end_x, end_y, zero fill
	output logic [lsbg_pkg::OUT_DW-1:0]  m_tdata,
	output logic                         m_tlast   // scan_end
);
	import lsbg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lsbg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsbg_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_range  (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second request taken");

	// an empty group only closes a scan
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[36:24] == 13'd0) |-> m_tlast) else $error("empty group mid scan");

	// an empty result is never large enough
	a_empty_small: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38] |-> (m_tdata[36:24] != 13'd0)) else $error("empty yet large");

endmodule
`default_nettype wire

// ===== hw/rtl/lsbg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsbg_ctrl: sequencer of the breakpoint grouper
// Steps each kept beam through rotation, scaling, distance and occlusion tests,
// then starts, joins or breaks the open group; the last beam of a scan closes it.
// ----------------------------------------------------------------------------
`default_nettype none
module lsbg_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  lsbg_pkg::sts_t sts,
	output lsbg_pkg::cmd_t cmd
);
	import lsbg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ROUTE, S_CORDIC, S_SCALE, S_ROUND, S_MUL1, S_MUL2,
		S_DECIDE, S_APPLY, S_BREAK, S_LAST
	} state_t;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	state_t            tail;

	// after a group update or a dropped beam, close the scan or wait for the next request
	assign tail = sts.last ? S_LAST : S_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.iter = iter_q;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ROUTE;
				end
			end
			S_ROUTE:  state_d = sts.kept ? S_CORDIC : tail;
			S_CORDIC: begin
				cmd.iter_en = 1'b1;
				if (iter_q == ITER_W'(15)) state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_APPLY;
			end
			S_APPLY: begin
				priority if (!sts.grp_open) begin
					cmd.start = 1'b1;
					state_d   = tail;
				end else if (sts.near) begin
					cmd.add_pt = 1'b1;
					state_d    = tail;
				end else begin
					state_d = S_BREAK;
				end
			end
			S_BREAK: begin
				if (sts.out_free) begin
					cmd.emit_brk = 1'b1;
					cmd.start    = 1'b1;
					state_d      = tail;
				end
			end
			S_LAST: begin
				if (sts.out_free) begin
					cmd.emit_last = 1'b1;
					cmd.close     = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and rotation step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= (state_q == S_CORDIC) ? iter_q + ITER_W'(1) : '0;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lsbg_dpath.sv =====
// ----------------------------------------------------------------------------
// lsbg_dpath: datapath of the breakpoint grouper
// Config registers, beam tracking, rotation unit, multipliers, open group
// state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lsbg_dpath (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [lsbg_pkg::CFG_AW-1:0]     cfg_addr,
	input  wire  [lsbg_pkg::CFG_DW-1:0]     cfg_wdata,
	input  wire  [lsbg_pkg::RANGE_W-1:0]    in_range,
	input  wire                             in_last,
	input  lsbg_pkg::cmd_t                  cmd,
	output lsbg_pkg::sts_t                  sts,
	input  wire                             out_ready,
	output logic                            out_valid,
	output logic [lsbg_pkg::OUT_DW-1:0]     out_data,
	output logic                            out_last
);
	import lsbg_pkg::*;

	// configuration
	logic [15:0]      min_r_q, max_r_q, ang_start_q, ang_step_q;
	logic [15:0]      gap_q, gpr_q, vis_q;
	logic [CNT_W-1:0] min_pts_q;

	// beam tracking
	logic [ANG_W-1:0]   beam_ang_q, ang_q;
	logic [IDX_W-1:0]   beam_num_q, idx_q;
	logic               fresh_q, last_q, kept_q;
	logic [RANGE_W-1:0] r_q;
	logic [ANG_W-1:0]   ang_now;

	// rotation
	logic signed [ROT_W-1:0] cx_q, cy_q, c_rot, s_rot;
	logic signed [ZW-1:0]    z_q;
	logic signed [ROT_W-1:0] sx, sy;

	// scaling
	logic signed [49:0]      px_prod_q, py_prod_q;
	logic signed [COORD_W-1:0] px_q, py_q;

	// distance and occlusion
	logic signed [COORD_W:0]   dx, dy;
	logic [35:0]               sqx_q, sqy_q;
	logic [31:0]               thr_prod_q, vr_q;
	logic signed [33:0]        cra_q, crb_q;
	logic [36:0]               d2_q;
	logic [33:0]               thr2_q;
	logic [47:0]               rhs_q;
	logic [50:0]               lhs_q;
	logic [16:0]               thr;
	logic signed [34:0]        cr;
	logic                      join_q, hide_q, newvis_q;

	// open group
	logic                      grp_open_q, open_vis_q;
	logic [IDX_W-1:0]          first_idx_q, end_idx_q;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, end_x_q, end_y_q;
	logic [RANGE_W-1:0]        end_r_q;
	logic [CNT_W-1:0]          count_q;

	// result register
	logic              out_valid_q, out_last_q;
	logic [OUT_DW-1:0] out_data_q;

	assign ang_now = fresh_q ? ang_start_q : beam_ang_q;

	// write config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_r_q     <= 16'd0;
			max_r_q     <= 16'd65535;
			ang_start_q <= 16'd0;
			ang_step_q  <= 16'd16;
			gap_q       <= 16'd200;
			gpr_q       <= 16'd0;
			vis_q       <= 16'd0;
			min_pts_q   <= 13'd5;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_MIN_RANGE:  min_r_q     <= cfg_wdata;
				REG_MAX_RANGE:  max_r_q     <= cfg_wdata;
				REG_ANG_START:  ang_start_q <= cfg_wdata;
				REG_ANG_STEP:   ang_step_q  <= cfg_wdata;
				REG_GAP:        gap_q       <= cfg_wdata;
				REG_GAP_PER_R:  gpr_q       <= cfg_wdata;
				REG_VIS_SINE:   vis_q       <= cfg_wdata;
				REG_MIN_POINTS: min_pts_q   <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// take a request and advance beam tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_ang_q <= '0;
			beam_num_q <= '0;
			fresh_q    <= 1'b1;
			last_q     <= 1'b0;
			kept_q     <= 1'b0;
		end else if (cmd.load) begin
			beam_ang_q <= ang_now + ang_step_q;
			beam_num_q <= in_last ? '0 : beam_num_q + IDX_W'(1);
			fresh_q    <= in_last;
			last_q     <= in_last;
			kept_q     <= (min_r_q <= in_range) && (in_range <= max_r_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q   <= in_range;
			ang_q <= ang_now;
			idx_q <= beam_num_q;
		end
	end

	// rotation: one step per cycle, seeded on each request
	assign sx = shr_tz(cy_q, cmd.iter);
	assign sy = shr_tz(cx_q, cmd.iter);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= CORDIC_K;
			cy_q <= '0;
			z_q  <= $signed({4'b0, ang_now[13:0]});
		end else if (cmd.iter_en) begin
			if (!z_q[ZW-1]) begin
				cx_q <= cx_q - sx;
				cy_q <= cy_q + sy;
				z_q  <= z_q - atan_lut(cmd.iter);
			end else begin
				cx_q <= cx_q + sx;
				cy_q <= cy_q - sy;
				z_q  <= z_q + atan_lut(cmd.iter);
			end
		end
	end

	// quadrant fold
	always_comb begin
		unique case (ang_q[15:14])
			2'd0: begin c_rot = cx_q;  s_rot = cy_q;  end
			2'd1: begin c_rot = -cy_q; s_rot = cx_q;  end
			2'd2: begin c_rot = -cx_q; s_rot = -cy_q; end
			default: begin c_rot = cy_q; s_rot = -cx_q; end
		endcase
	end

	// scale, round half away from zero, saturate
	function automatic logic signed [COORD_W-1:0] rnd_sat(input logic signed [49:0] p);
		logic [49:0] mag;
		logic [19:0] m;
		mag = p[49] ? 50'(-p) : 50'(p);
		m   = 20'((mag + (50'(1) << 29)) >> 30);
		if (m > COORD_MAX) m = COORD_MAX;
		return p[49] ? -$signed(COORD_W'(m)) : $signed(COORD_W'(m));
	endfunction

	assign dx  = $signed({px_q[COORD_W-1], px_q}) - $signed({end_x_q[COORD_W-1], end_x_q});
	assign dy  = $signed({py_q[COORD_W-1], py_q}) - $signed({end_y_q[COORD_W-1], end_y_q});
	assign thr = 17'(gap_q) + 17'(thr_prod_q[31:16]);
	assign cr  = 35'(cra_q) - 35'(crb_q);

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			px_prod_q <= $signed({1'b0, r_q}) * c_rot;
			py_prod_q <= $signed({1'b0, r_q}) * s_rot;
		end
		if (cmd.round) begin
			px_q <= rnd_sat(px_prod_q);
			py_q <= rnd_sat(py_prod_q);
		end
		if (cmd.mul1) begin
			sqx_q      <= 36'(dx * dx);
			sqy_q      <= 36'(dy * dy);
			thr_prod_q <= r_q * gpr_q;
			vr_q       <= vis_q * r_q;
			cra_q      <= end_x_q * py_q;
			crb_q      <= px_q * end_y_q;
		end
		if (cmd.mul2) begin
			d2_q   <= 37'(sqx_q) + 37'(sqy_q);
			thr2_q <= thr * thr;
			rhs_q  <= vr_q * end_r_q;
			lhs_q  <= {(cr[34] ? 35'(-cr) : 35'(cr)), 16'd0};
		end
		if (cmd.decide) begin
			join_q   <= d2_q < 37'(thr2_q);
			hide_q   <= (lhs_q < 51'(rhs_q)) && (r_q < end_r_q);
			newvis_q <= (lhs_q > 51'(rhs_q)) || (r_q < end_r_q);
		end
	end

	// open group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_open_q <= 1'b0;
			open_vis_q <= 1'b1;
			count_q    <= '0;
		end else begin
			priority if (cmd.start) begin
				grp_open_q <= 1'b1;
				open_vis_q <= grp_open_q ? newvis_q : 1'b1;
				count_q    <= CNT_W'(1);
			end else if (cmd.add_pt) begin
				if (count_q < COUNT_MAX) count_q <= count_q + CNT_W'(1);
			end else if (cmd.close) begin
				grp_open_q <= 1'b0;
				open_vis_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			first_idx_q <= idx_q;
			first_x_q   <= px_q;
			first_y_q   <= py_q;
		end
		if (cmd.start || cmd.add_pt) begin
			end_idx_q <= idx_q;
			end_x_q   <= px_q;
			end_y_q   <= py_q;
			end_r_q   <= r_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (cmd.emit_brk || cmd.emit_last) begin
			out_valid_q <= 1'b1;
			out_last_q  <= cmd.emit_last;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_brk || (cmd.emit_last && grp_open_q)) begin
			out_data_q <= {5'd0, end_y_q, end_x_q, first_y_q, first_x_q,
				count_q >= min_pts_q, open_vis_q & ~(cmd.emit_brk & hide_q),
				count_q, end_idx_q, first_idx_q};
		end else if (cmd.emit_last) begin
			out_data_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	assign sts.kept     = kept_q;
	assign sts.last     = last_q;
	assign sts.grp_open = grp_open_q;
	assign sts.near     = join_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire
